// ===== rtl/nkis_pkg.sv =====
// Shared types and constants for the nearest-K insertion select block.
package nkis_pkg;

   localparam int DIST_W = 32;
   localparam int ID_W   = 16;
   localparam int YAW_W  = 16;
   localparam int RANK_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [DIST_W-1:0] LIMIT_RESET  = 32'd422500;
   localparam logic [DIST_W-1:0] CARRY_RESET  = 32'd2500;
   localparam logic [YAW_W-1:0]  WINDOW_RESET = 16'h2000;

   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_DIST = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARRY_DIST = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_YAW_WINDOW = 2'd2;

   typedef struct packed {
      logic              first;
      logic              last;
      logic [DIST_W-1:0] dist_sq;
      logic [ID_W-1:0]   item_id;
      logic              removed;
      logic [YAW_W-1:0]  viewer_yaw;
      logic [YAW_W-1:0]  bearing_yaw;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic              slot_valid;
      logic [ID_W-1:0]   slot_id;
      logic [DIST_W-1:0] slot_dist_sq;
      logic              carry_valid;
      logic [ID_W-1:0]   carry_id;
      logic              last_result;
   } rsp_type;

   // Classified candidate handed from the front to the list.
   typedef struct packed {
      logic              first;
      logic              last;
      logic              removed;
      logic              carry_ok;
      logic [DIST_W-1:0] dist_sq;
      logic [ID_W-1:0]   item_id;
   } work_type;

endpackage

// ===== rtl/nkis_front.sv =====
// Front stage: accepts requests and classifies them for carry eligibility.
module nkis_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  nkis_pkg::req_type                req_data,
   input  logic [nkis_pkg::DIST_W-1:0]      carry_dist_sq,
   input  logic [nkis_pkg::YAW_W-1:0]       yaw_window,
   output logic                             push_valid,
   output nkis_pkg::work_type               push_data,
   input  logic                             queue_full
);
   import nkis_pkg::*;

   logic                valid_ff, valid_in;
   work_type            work_ff, work_in;
   logic [YAW_W-1:0]    yaw_diff;
   logic [YAW_W:0]      yaw_mag;
   logic                accept;

   assign req_stall  = valid_ff & queue_full;
   assign accept     = req_valid & ~req_stall;
   assign push_valid = valid_ff;
   assign push_data  = work_ff;

   always_comb begin
      yaw_diff = req_data.viewer_yaw - req_data.bearing_yaw;
      // wrap to signed and take the magnitude, 0..32768
      if (yaw_diff[YAW_W-1]) begin
         yaw_mag = (YAW_W+1)'(1 << YAW_W) - {1'b0, yaw_diff};
      end else begin
         yaw_mag = {1'b0, yaw_diff};
      end
      work_in.first    = req_data.first;
      work_in.last     = req_data.last;
      work_in.removed  = req_data.removed;
      work_in.dist_sq  = req_data.dist_sq;
      work_in.item_id  = req_data.item_id;
      work_in.carry_ok = (req_data.dist_sq < carry_dist_sq) &&
                         (yaw_mag < {1'b0, yaw_window});
      valid_in = accept | (valid_ff & queue_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

// ===== rtl/nkis_queue.sv =====
// Short queue of classified candidates between the front and the list.
module nkis_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  nkis_pkg::work_type    push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output nkis_pkg::work_type    head_data
);
   import nkis_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                push;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign push       = push_valid & ~full;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/nkis_list.sv =====
// Back end: sorted slot list with one-step insertion and a snapshot for emission.
module nkis_list #(
   parameter int NEAREST_COUNT = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [nkis_pkg::DIST_W-1:0]   limit_dist_sq,
   input  logic                          head_valid,
   input  nkis_pkg::work_type            head_data,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output nkis_pkg::rsp_type             rsp_data
);
   import nkis_pkg::*;

   localparam int K     = NEAREST_COUNT;
   localparam int CNT_W = (K > 1) ? $clog2(K) : 1;

   logic [DIST_W-1:0] dist_ff [K];
   logic [DIST_W-1:0] dist_in [K];
   logic [ID_W-1:0]   id_ff   [K];
   logic [ID_W-1:0]   id_in   [K];
   logic [K-1:0]      full_ff, full_in;
   logic              carry_ff, carry_in;
   logic [ID_W-1:0]   carry_id_ff, carry_id_in;

   logic [DIST_W-1:0] base_dist [K];
   logic [ID_W-1:0]   base_id   [K];
   logic [K-1:0]      base_full;
   logic [K-1:0]      lt;
   logic              base_carry;
   logic [ID_W-1:0]   base_carry_id;

   logic [DIST_W-1:0] snap_dist_ff [K];
   logic [ID_W-1:0]   snap_id_ff   [K];
   logic [K-1:0]      snap_full_ff;
   logic              snap_carry_ff;
   logic [ID_W-1:0]   snap_carry_id_ff;
   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_accept, load, done;

   // hold a new last-marked candidate until the previous run has drained
   assign pop        = head_valid & ~(head_data.last & busy_ff);
   assign load       = pop & head_data.last;
   assign rsp_valid  = busy_ff;
   assign rsp_accept = busy_ff & ~rsp_stall;
   assign done       = (cnt_ff == CNT_W'(K - 1));

   always_comb begin
      for (int k = 0; k < K; k++) begin
         base_dist[k] = head_data.first ? limit_dist_sq : dist_ff[k];
         base_id[k]   = head_data.first ? '0 : id_ff[k];
         base_full[k] = head_data.first ? 1'b0 : full_ff[k];
         lt[k]        = head_data.dist_sq < base_dist[k];
      end
      base_carry    = head_data.first ? 1'b0 : carry_ff;
      base_carry_id = head_data.first ? '0 : carry_id_ff;

      // slots are sorted, so lt is a thermometer; insert at its first set bit
      if (!head_data.removed && lt[0]) begin
         dist_in[0] = head_data.dist_sq;
         id_in[0]   = head_data.item_id;
         full_in[0] = 1'b1;
      end else begin
         dist_in[0] = base_dist[0];
         id_in[0]   = base_id[0];
         full_in[0] = base_full[0];
      end
      for (int k = 1; k < K; k++) begin
         if (head_data.removed || !lt[k]) begin
            dist_in[k] = base_dist[k];
            id_in[k]   = base_id[k];
            full_in[k] = base_full[k];
         end else if (!lt[k-1]) begin
            dist_in[k] = head_data.dist_sq;
            id_in[k]   = head_data.item_id;
            full_in[k] = 1'b1;
         end else begin
            dist_in[k] = base_dist[k-1];
            id_in[k]   = base_id[k-1];
            full_in[k] = base_full[k-1];
         end
      end

      if (!head_data.removed && lt[K-1] && head_data.carry_ok) begin
         carry_in    = 1'b1;
         carry_id_in = head_data.item_id;
      end else begin
         carry_in    = base_carry;
         carry_id_in = base_carry_id;
      end

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (rsp_accept) begin
         if (done) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < K; k++) begin
            dist_ff[k] <= LIMIT_RESET;
            id_ff[k]   <= '0;
         end
         full_ff     <= '0;
         carry_ff    <= 1'b0;
         carry_id_ff <= '0;
         busy_ff     <= 1'b0;
         cnt_ff      <= '0;
      end else begin
         if (pop) begin
            for (int k = 0; k < K; k++) begin
               dist_ff[k] <= dist_in[k];
               id_ff[k]   <= id_in[k];
            end
            full_ff     <= full_in;
            carry_ff    <= carry_in;
            carry_id_ff <= carry_id_in;
         end
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end

      // snapshot the updated list, then advance it one slot per response
      if (load) begin
         for (int k = 0; k < K; k++) begin
            snap_dist_ff[k] <= dist_in[k];
            snap_id_ff[k]   <= id_in[k];
         end
         snap_full_ff     <= full_in;
         snap_carry_ff    <= carry_in;
         snap_carry_id_ff <= carry_id_in;
      end else if (rsp_accept) begin
         for (int k = 0; k < K - 1; k++) begin
            snap_dist_ff[k] <= snap_dist_ff[k+1];
            snap_id_ff[k]   <= snap_id_ff[k+1];
            snap_full_ff[k] <= snap_full_ff[k+1];
         end
      end
   end

   always_comb begin
      rsp_data.rank         = RANK_W'(cnt_ff);
      rsp_data.slot_valid   = snap_full_ff[0];
      rsp_data.slot_id      = snap_id_ff[0];
      rsp_data.slot_dist_sq = snap_dist_ff[0];
      rsp_data.carry_valid  = snap_carry_ff;
      rsp_data.carry_id     = snap_carry_id_ff;
      rsp_data.last_result  = done;
   end

endmodule

// ===== rtl/nearest_k_insertion_select.sv =====
// Top level of the nearest-K insertion select block.
// Takes one candidate per cycle while not stalled and keeps the NEAREST_COUNT nearest
// in a sorted slot list; each candidate is compared against all slots at once and
// inserted with a one-step shift. A front stage classifies carry eligibility and
// feeds a four-entry queue ahead of the list. A last-marked candidate copies the
// list into an output buffer that returns NEAREST_COUNT responses, one per cycle
// while rsp_stall is low, as later candidates keep flowing; the next last-marked
// candidate waits in the queue until that buffer has drained.
module nearest_k_insertion_select #(
   parameter int NEAREST_COUNT = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  nkis_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output nkis_pkg::rsp_type                 rsp_data,
   input  logic                              csr_wr_en,
   input  logic [nkis_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nkis_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import nkis_pkg::*;

   logic [DIST_W-1:0] limit_ff;
   logic [DIST_W-1:0] carry_dist_ff;
   logic [YAW_W-1:0]  window_ff;

   logic              push_valid;
   work_type          push_data;
   logic              queue_full;
   logic              pop;
   logic              head_valid;
   work_type          head_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff      <= LIMIT_RESET;
         carry_dist_ff <= CARRY_RESET;
         window_ff     <= WINDOW_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LIMIT_DIST: limit_ff      <= csr_wdata[DIST_W-1:0];
            CSR_CARRY_DIST: carry_dist_ff <= csr_wdata[DIST_W-1:0];
            CSR_YAW_WINDOW: window_ff     <= csr_wdata[YAW_W-1:0];
            default: ;
         endcase
      end
   end

   nkis_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .carry_dist_sq (carry_dist_ff),
      .yaw_window    (window_ff),
      .push_valid    (push_valid),
      .push_data     (push_data),
      .queue_full    (queue_full)
   );

   nkis_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   nkis_list #(
      .NEAREST_COUNT (NEAREST_COUNT)
   ) u_list (
      .clock         (clock),
      .reset         (reset),
      .limit_dist_sq (limit_ff),
      .head_valid    (head_valid),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest-K insertion select block.
module tb;
   import nkis_pkg::*;

   localparam int SLOT_COUNT    = 16;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 410;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_data;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow copy of the registers and the nearest list.
   logic [DIST_W-1:0] limit_cfg;
   logic [DIST_W-1:0] carry_cfg;
   logic [YAW_W-1:0]  window_cfg;
   logic [DIST_W-1:0] near_dist [SLOT_COUNT];
   logic [ID_W-1:0]   near_id   [SLOT_COUNT];
   logic              near_full [SLOT_COUNT];
   logic              carry_seen;
   logic [ID_W-1:0]   carry_pick;

   rsp_type           expected_slots [$];
   int                error_count;
   int                send_idle_pct;
   int                recv_stall_pct;
   logic [DIST_W-1:0] recent_dist;

   nearest_k_insertion_select #(
      .NEAREST_COUNT(SLOT_COUNT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void clear_nearest();
      int k;
      for (k = 0; k < SLOT_COUNT; k++) begin
         near_dist[k] = limit_cfg;
         near_id[k]   = '0;
         near_full[k] = 1'b0;
      end
      carry_seen = 1'b0;
      carry_pick = '0;
   endfunction

   // Insert one candidate into the shadow list; queue the slots on a last mark.
   function automatic void predict_request(req_type r);
      int               pos;
      int               k;
      logic [YAW_W-1:0] facing;
      logic [YAW_W:0]   facing_mag;
      rsp_type          slot;
      if (r.first)
         clear_nearest();
      if (!r.removed) begin
         pos = SLOT_COUNT;
         for (k = SLOT_COUNT - 1; k >= 0; k--)
            if (r.dist_sq < near_dist[k])
               pos = k;
         if (pos < SLOT_COUNT) begin
            for (k = SLOT_COUNT - 1; k > pos; k--) begin
               near_dist[k] = near_dist[k-1];
               near_id[k]   = near_id[k-1];
               near_full[k] = near_full[k-1];
            end
            near_dist[pos] = r.dist_sq;
            near_id[pos]   = r.item_id;
            near_full[pos] = 1'b1;
            facing     = r.viewer_yaw - r.bearing_yaw;
            facing_mag = facing[YAW_W-1] ? 17'h1_0000 - {1'b0, facing} : {1'b0, facing};
            if (r.dist_sq < carry_cfg && facing_mag < {1'b0, window_cfg}) begin
               carry_seen = 1'b1;
               carry_pick = r.item_id;
            end
         end
      end
      if (r.last) begin
         for (k = 0; k < SLOT_COUNT; k++) begin
            slot.rank         = k[RANK_W-1:0];
            slot.slot_valid   = near_full[k];
            slot.slot_id      = near_id[k];
            slot.slot_dist_sq = near_dist[k];
            slot.carry_valid  = carry_seen;
            slot.carry_id     = carry_seen ? carry_pick : '0;
            slot.last_result  = (k == SLOT_COUNT - 1);
            expected_slots.push_back(slot);
         end
      end
   endfunction

   function automatic void check_field(string name, logic [DIST_W-1:0] want,
                                       logic [DIST_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_slots.size() == 0) begin
               $error("unexpected response, rank %0d", rsp_data.rank);
               error_count++;
            end else begin
               want = expected_slots.pop_front();
               check_field("rank", DIST_W'(want.rank), DIST_W'(rsp_data.rank));
               check_field("slot_valid", DIST_W'(want.slot_valid),
                           DIST_W'(rsp_data.slot_valid));
               check_field("slot_id", DIST_W'(want.slot_id), DIST_W'(rsp_data.slot_id));
               check_field("slot_dist_sq", want.slot_dist_sq, rsp_data.slot_dist_sq);
               check_field("carry_valid", DIST_W'(want.carry_valid),
                           DIST_W'(rsp_data.carry_valid));
               check_field("carry_id", DIST_W'(want.carry_id), DIST_W'(rsp_data.carry_id));
               check_field("last_result", DIST_W'(want.last_result),
                           DIST_W'(rsp_data.last_result));
            end
         end
      end
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   function automatic req_type candidate(logic first, logic last, logic [DIST_W-1:0] dist_val,
                                         logic [ID_W-1:0] id, logic removed,
                                         logic [YAW_W-1:0] viewer, logic [YAW_W-1:0] bearing);
      req_type c;
      c.first       = first;
      c.last        = last;
      c.dist_sq     = dist_val;
      c.item_id     = id;
      c.removed     = removed;
      c.viewer_yaw  = viewer;
      c.bearing_yaw = bearing;
      return c;
   endfunction

   task automatic send_request(req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold off requests until every queued slot has come back, then let the pipe empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_slots.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_LIMIT_DIST: limit_cfg  = value;
         CSR_CARRY_DIST: carry_cfg  = value;
         CSR_YAW_WINDOW: window_cfg = value[YAW_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [DIST_W-1:0] pick_distance();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         3, 4:    return $urandom_range(carry_cfg);
         8:       return recent_dist;
         9:       return limit_cfg;
         default: return $urandom_range(limit_cfg);
      endcase
   endfunction

   // Place the bearing near the window edge half the time.
   function automatic logic [YAW_W-1:0] pick_bearing(logic [YAW_W-1:0] viewer);
      logic [YAW_W-1:0] offset;
      if ($urandom_range(1))
         return YAW_W'($urandom);
      offset = YAW_W'($urandom_range(32'(window_cfg) + 32'd1));
      return $urandom_range(1) ? viewer - offset : viewer + offset;
   endfunction

   task automatic randomize_settings();
      logic [DIST_W-1:0] lim;
      case ($urandom_range(3))
         0:       lim = '1;
         1:       lim = $urandom;
         2:       lim = LIMIT_RESET;
         default: lim = $urandom_range(2000000, 1000);
      endcase
      write_csr(CSR_LIMIT_DIST, lim);
      write_csr(CSR_CARRY_DIST, $urandom_range(lim));
      case ($urandom_range(3))
         0:       write_csr(CSR_YAW_WINDOW, 32'd32768);
         1:       write_csr(CSR_YAW_WINDOW, WINDOW_RESET);
         default: write_csr(CSR_YAW_WINDOW, $urandom_range(32768, 0));
      endcase
   endtask

   task automatic test_reset_list();
      // Removed candidate with a last mark still emits the list.
      send_request(candidate(1'b0, 1'b1, '0, '1, 1'b1, '0, '0));
      send_request(candidate(1'b1, 1'b1, 32'd100, 16'd1, 1'b0, 16'h0000, 16'h0000));
   endtask

   task automatic test_yaw_and_ties();
      send_request(candidate(1'b1, 1'b0, 32'd10, 16'd2, 1'b0, 16'h0000, 16'h8000));
      send_request(candidate(1'b0, 1'b0, 32'd20, 16'd3, 1'b0, 16'h1FFF, 16'h0000));
      send_request(candidate(1'b0, 1'b0, 32'd30, 16'd4, 1'b0, 16'h0000, 16'h2000));
      // Tie on distance: the later one lands behind.
      send_request(candidate(1'b0, 1'b0, 32'd20, 16'd5, 1'b0, 16'hFFFF, 16'h0000));
      send_request(candidate(1'b0, 1'b0, CARRY_RESET, 16'd6, 1'b0, 16'h1234, 16'h1234));
      send_request(candidate(1'b0, 1'b0, LIMIT_RESET, 16'd7, 1'b0, 16'h0000, 16'h0000));
      send_request(candidate(1'b0, 1'b1, '1, 16'd8, 1'b0, 16'h0000, 16'h0000));
   endtask

   task automatic test_run_without_first();
      send_request(candidate(1'b0, 1'b1, '0, 16'hFFFF, 1'b0, 16'h8000, 16'h7FFF));
   endtask

   task automatic test_limit_mid_run();
      send_request(candidate(1'b1, 1'b0, 32'd5, 16'd9, 1'b0, 16'h0000, 16'h0000));
      wait_drained();
      write_csr(CSR_LIMIT_DIST, '0);
      // Slots already held keep the old limit until the next clear.
      send_request(candidate(1'b0, 1'b1, 32'd7, 16'd10, 1'b0, 16'h0000, 16'h0000));
      send_request(candidate(1'b1, 1'b1, '0, 16'd11, 1'b0, 16'h0000, 16'h0000));
      wait_drained();
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_LIMIT_DIST, '1);
      write_csr(CSR_CARRY_DIST, '1);
      write_csr(CSR_YAW_WINDOW, 32'd32768);
      send_request(candidate(1'b1, 1'b0, 32'hFFFF_FFFE, 16'hAAAA, 1'b0, 16'h8001, 16'h0000));
      send_request(candidate(1'b0, 1'b0, '1, 16'h5555, 1'b0, 16'h0000, 16'h0000));
      send_request(candidate(1'b0, 1'b1, '0, 16'h5555, 1'b0, 16'h0000, 16'h8000));
      wait_drained();
      write_csr(CSR_CARRY_DIST, '0);
      write_csr(CSR_YAW_WINDOW, '0);
      write_csr(CSR_SPARE, '1);
      send_request(candidate(1'b1, 1'b1, '0, 16'h1234, 1'b0, 16'h0007, 16'h0007));
      wait_drained();
   endtask

   // Mostly whole runs with random content, with stray marks and removed candidates mixed in.
   task automatic test_random_traffic(int idle_pct, int stall_pct, int item_goal,
                                      bit pause_midway);
      int      sent;
      int      run_len;
      bit      paused;
      req_type c;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent   = 0;
      paused = 1'b0;
      randomize_settings();
      while (sent < item_goal) begin
         run_len = $urandom_range(30, 1);
         if (run_len > item_goal - sent)
            run_len = item_goal - sent;
         for (int k = 0; k < run_len; k++) begin
            c.first       = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0);
            c.last        = (k == run_len - 1) || ($urandom_range(49) == 0);
            c.removed     = ($urandom_range(9) == 0);
            c.dist_sq     = pick_distance();
            c.item_id     = ID_W'($urandom);
            c.viewer_yaw  = YAW_W'($urandom);
            c.bearing_yaw = pick_bearing(c.viewer_yaw);
            send_request(c);
            recent_dist = c.dist_sq;
            sent++;
         end
         if (pause_midway && !paused && sent >= item_goal / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end
      wait_drained();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      recent_dist    = '0;
      limit_cfg  = LIMIT_RESET;
      carry_cfg  = CARRY_RESET;
      window_cfg = WINDOW_RESET;
      clear_nearest();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 25;
      recv_stall_pct = 25;
      test_reset_list();
      test_yaw_and_ties();
      test_run_without_first();
      test_limit_mid_run();
      test_register_extremes();
      test_random_traffic(35, 55, RANDOM_ITEMS / 3, 1'b0);
      test_random_traffic(55, 35, RANDOM_ITEMS / 3, 1'b1);
      test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3), 1'b0);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
